// ===== sv/ihq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed max-heap package
// Shared widths, operation and status codes, datapath commands and the
// status bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package ihq_pkg;

  // Default number of ids held by the heap.
  localparam int NUM_IDS_DEF = 1024;

  // Fixed field widths of the two channels.
  localparam int OP_W  = 2;
  localparam int ID_W  = 10;
  localparam int PRI_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // One step of datapath work, issued by the controller each cycle.
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_SWEEP,
    CMD_CAPTURE,
    CMD_ERR_RANGE,
    CMD_ERR_ABSENT,
    CMD_ERR_EMPTY,
    CMD_CLEAR,
    CMD_SET_WR,
    CMD_RD_POS,
    CMD_CHK,
    CMD_INS,
    CMD_PRES,
    CMD_POP_RD,
    CMD_POP_ID,
    CMD_RM_START,
    CMD_LD_LAST,
    CMD_LD_LPR,
    CMD_UP_RD,
    CMD_UP_PR,
    CMD_UP_CMP,
    CMD_DN_RD,
    CMD_DN_C1,
    CMD_DN_C2,
    CMD_DN_CMP,
    CMD_FIN,
    CMD_TOP_RD,
    CMD_RESULT
  } cmd_t;

  // Flags the controller steers by.
  typedef struct packed {
    op_t  op;
    logic range_err;
    logic heap_empty;
    logic present;
    logic last_eq;
    logic up_ok;
    logic up_swap;
    logic dn_ok;
    logic dn_swap;
    logic sweep_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== sv/ihq_if.sv =====
// ----------------------------------------------------------------------------
// Indexed max-heap channel interfaces
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one heap operation per transfer.
interface ihq_in_if;
  logic                                valid;
  logic                                ready;
  logic [ihq_pkg::OP_W-1:0]            operation;
  logic [ihq_pkg::ID_W-1:0]            item_id;
  logic signed [ihq_pkg::PRI_W-1:0]    priority_req;

  modport source (output valid, operation, item_id, priority_req, input ready);
  modport sink   (input valid, operation, item_id, priority_req, output ready);
endinterface

// Result channel: one result per operation.
interface ihq_out_if;
  logic                                valid;
  logic                                ready;
  logic [ihq_pkg::ST_W-1:0]            status;
  logic [ihq_pkg::ID_W-1:0]            popped_id;
  logic                                top_valid;
  logic [ihq_pkg::ID_W-1:0]            top_id;
  logic [ihq_pkg::CNT_W-1:0]           entry_count;

  modport source (output valid, status, popped_id, top_valid, top_id, entry_count,
                  input ready);
  modport sink   (input valid, status, popped_id, top_valid, top_id, entry_count,
                  output ready);
endinterface

// ===== sv/ihq_datapath.sv =====
// ----------------------------------------------------------------------------
// Indexed max-heap datapath
// Priority, slot and position memories, the sift registers and comparators,
// and the result register. Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module ihq_datapath #(
  parameter int NUM_IDS = ihq_pkg::NUM_IDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ihq_pkg::cmd_t                    cmd,
  output ihq_pkg::dp_stat_t                stat,
  input  logic [ihq_pkg::OP_W-1:0]         in_operation,
  input  logic [ihq_pkg::ID_W-1:0]         in_item_id,
  input  logic signed [ihq_pkg::PRI_W-1:0] in_priority_req,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ihq_pkg::ST_W-1:0]         out_status,
  output logic [ihq_pkg::ID_W-1:0]         out_popped_id,
  output logic                             out_top_valid,
  output logic [ihq_pkg::ID_W-1:0]         out_top_id,
  output logic [ihq_pkg::CNT_W-1:0]        out_entry_count
);

  localparam int IW = $clog2(NUM_IDS);
  localparam int PW = $clog2(NUM_IDS + 1);
  localparam int PRW = ihq_pkg::PRI_W;

  // Storage.
  logic signed [PRW-1:0] prio_mem [NUM_IDS];
  logic [IW-1:0]         slot_mem [NUM_IDS+1];
  logic [PW-1:0]         pos_mem  [NUM_IDS];

  logic signed [PRW-1:0] prio_q;
  logic [IW-1:0]         slot_q;
  logic [PW-1:0]         pos_q;

  // Memory port controls.
  logic                  prio_we, prio_re;
  logic [IW-1:0]         prio_ra;
  logic                  slot_we, slot_re;
  logic [PW-1:0]         slot_wa, slot_ra;
  logic [IW-1:0]         slot_wd;
  logic                  pos_we, pos_re;
  logic [IW-1:0]         pos_wa;
  logic [PW-1:0]         pos_wd;

  // Operation and sift registers.
  ihq_pkg::op_t          op_r;
  logic [IW-1:0]         id_r;
  logic                  oor_r;
  logic signed [PRW-1:0] pin_r;
  logic [PW-1:0]         cnt_r;
  logic [PW-1:0]         k_r;
  logic [PW-1:0]         c_r;
  logic                  c1ok_r;
  logic [PW-1:0]         p_r;
  logic                  inr_r;
  logic                  last_eq_r;
  logic [IW-1:0]         mid_r;
  logic signed [PRW-1:0] mpr_r;
  logic [IW-1:0]         cid_r;
  logic signed [PRW-1:0] cpr_r;
  logic [IW-1:0]         c1id_r;
  logic [IW-1:0]         sw_r;
  ihq_pkg::status_t      status_r;
  logic [IW-1:0]         popped_r;

  // Result register.
  logic                  out_valid_r;
  ihq_pkg::status_t      out_status_r;
  logic [ihq_pkg::ID_W-1:0]  out_popped_r;
  logic                  out_top_valid_r;
  logic [ihq_pkg::ID_W-1:0]  out_top_id_r;
  logic [ihq_pkg::CNT_W-1:0] out_count_r;

  // Comparison and selection.
  logic [PW:0]           k2;
  logic [PW:0]           k2p1;
  logic [PW-1:0]         c_inc;
  logic                  up_swap;
  logic                  pick1;
  logic [IW-1:0]         bid;
  logic signed [PRW-1:0] bpr;
  logic [PW-1:0]         bpos;
  logic                  dn_swap;

  assign k2      = {k_r, 1'b0};
  assign k2p1    = {k_r, 1'b1};
  assign c_inc   = c_r + PW'(1);
  assign up_swap = prio_q < mpr_r;
  assign pick1   = c1ok_r && (cpr_r < prio_q);
  assign bid     = pick1 ? c1id_r : cid_r;
  assign bpr     = pick1 ? prio_q : cpr_r;
  assign bpos    = pick1 ? c_inc : c_r;
  assign dn_swap = mpr_r < bpr;

  // Status back to the controller.
  always_comb begin
    stat.op         = op_r;
    stat.range_err  = oor_r;
    stat.heap_empty = (cnt_r == '0);
    stat.present    = inr_r && (slot_q == id_r);
    stat.last_eq    = last_eq_r;
    stat.up_ok      = (k_r > PW'(1));
    stat.up_swap    = up_swap;
    stat.dn_ok      = (k2 <= {1'b0, cnt_r});
    stat.dn_swap    = dn_swap;
    stat.sweep_last = (sw_r == IW'(NUM_IDS - 1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // Memory port selection for the current command.
  always_comb begin
    prio_we = 1'b0;
    prio_re = 1'b0;
    prio_ra = slot_q;
    slot_we = 1'b0;
    slot_re = 1'b0;
    slot_wa = k_r;
    slot_wd = mid_r;
    slot_ra = PW'(1);
    pos_we  = 1'b0;
    pos_re  = 1'b0;
    pos_wa  = mid_r;
    pos_wd  = k_r;
    case (cmd)
      ihq_pkg::CMD_SWEEP: begin
        pos_we = 1'b1;
        pos_wa = sw_r;
        pos_wd = '0;
      end
      ihq_pkg::CMD_SET_WR: begin
        prio_we = 1'b1;
        pos_re  = 1'b1;
      end
      ihq_pkg::CMD_RD_POS: pos_re = 1'b1;
      ihq_pkg::CMD_CHK: begin
        slot_re = 1'b1;
        slot_ra = pos_q;
      end
      ihq_pkg::CMD_POP_RD, ihq_pkg::CMD_TOP_RD: slot_re = 1'b1;
      ihq_pkg::CMD_RM_START: begin
        pos_we  = 1'b1;
        pos_wa  = id_r;
        pos_wd  = '0;
        slot_re = 1'b1;
        slot_ra = cnt_r;
      end
      ihq_pkg::CMD_LD_LAST, ihq_pkg::CMD_UP_PR, ihq_pkg::CMD_DN_C2: prio_re = 1'b1;
      ihq_pkg::CMD_UP_RD: begin
        slot_re = 1'b1;
        slot_ra = k_r >> 1;
      end
      ihq_pkg::CMD_UP_CMP: begin
        slot_we = up_swap;
        slot_wd = cid_r;
        pos_we  = up_swap;
        pos_wa  = cid_r;
      end
      ihq_pkg::CMD_DN_RD: begin
        slot_re = 1'b1;
        slot_ra = k2[PW-1:0];
      end
      ihq_pkg::CMD_DN_C1: begin
        prio_re = 1'b1;
        slot_re = 1'b1;
        slot_ra = c1ok_r ? c_inc : c_r;
      end
      ihq_pkg::CMD_DN_CMP: begin
        slot_we = dn_swap;
        slot_wd = bid;
        pos_we  = dn_swap;
        pos_wa  = bid;
      end
      ihq_pkg::CMD_FIN: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  // Priority memory.
  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[id_r] <= pin_r;
    end
    if (prio_re) begin
      prio_q <= prio_mem[prio_ra];
    end
  end

  // Heap slot memory.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_ra];
    end
  end

  // Position memory.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (pos_re) begin
      pos_q <= pos_mem[id_r];
    end
  end

  // Control registers: count, sweep address and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result fills the register; a held one leaves on its transfer.
      if (cmd == ihq_pkg::CMD_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        ihq_pkg::CMD_SWEEP:    sw_r  <= sw_r + IW'(1);
        ihq_pkg::CMD_CLEAR:    cnt_r <= '0;
        ihq_pkg::CMD_INS:      cnt_r <= cnt_r + PW'(1);
        ihq_pkg::CMD_RM_START: cnt_r <= cnt_r - PW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers of the operation in progress.
  always_ff @(posedge clk) begin
    case (cmd)
      ihq_pkg::CMD_CAPTURE: begin
        op_r     <= ihq_pkg::op_t'(in_operation);
        id_r     <= IW'(in_item_id);
        oor_r    <= ({22'd0, in_item_id} >= 32'(NUM_IDS));
        pin_r    <= in_priority_req;
        status_r <= ihq_pkg::ST_OK;
        popped_r <= '0;
      end
      ihq_pkg::CMD_ERR_RANGE:  status_r <= ihq_pkg::ST_RANGE;
      ihq_pkg::CMD_ERR_ABSENT: status_r <= ihq_pkg::ST_ABSENT;
      ihq_pkg::CMD_ERR_EMPTY:  status_r <= ihq_pkg::ST_EMPTY;
      ihq_pkg::CMD_SET_WR: begin
        mid_r <= id_r;
        mpr_r <= pin_r;
      end
      ihq_pkg::CMD_CHK: begin
        p_r   <= pos_q;
        inr_r <= (pos_q != '0) && (pos_q <= cnt_r);
      end
      ihq_pkg::CMD_INS:  k_r <= cnt_r + PW'(1);
      ihq_pkg::CMD_PRES: k_r <= p_r;
      ihq_pkg::CMD_POP_ID: begin
        id_r     <= slot_q;
        popped_r <= slot_q;
        p_r      <= PW'(1);
      end
      ihq_pkg::CMD_RM_START: begin
        k_r       <= p_r;
        last_eq_r <= (p_r == cnt_r);
      end
      ihq_pkg::CMD_LD_LAST: mid_r <= slot_q;
      ihq_pkg::CMD_LD_LPR:  mpr_r <= prio_q;
      ihq_pkg::CMD_UP_PR:   cid_r <= slot_q;
      ihq_pkg::CMD_UP_CMP: begin
        if (up_swap) begin
          k_r <= k_r >> 1;
        end
      end
      ihq_pkg::CMD_DN_RD: begin
        c_r    <= k2[PW-1:0];
        c1ok_r <= (k2p1 <= {1'b0, cnt_r});
      end
      ihq_pkg::CMD_DN_C1: cid_r <= slot_q;
      ihq_pkg::CMD_DN_C2: begin
        cpr_r  <= prio_q;
        c1id_r <= slot_q;
      end
      ihq_pkg::CMD_DN_CMP: begin
        if (dn_swap) begin
          k_r <= bpos;
        end
      end
      ihq_pkg::CMD_RESULT: begin
        out_status_r    <= status_r;
        out_popped_r    <= ihq_pkg::ID_W'(popped_r);
        out_top_valid_r <= (cnt_r != '0);
        out_top_id_r    <= (cnt_r != '0) ? ihq_pkg::ID_W'(slot_q) : '0;
        out_count_r     <= ihq_pkg::CNT_W'(cnt_r);
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_popped_id   = out_popped_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_top_id      = out_top_id_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== sv/ihq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed max-heap controller
// Sequences the position sweep after reset, operation decode, sift up,
// sift down and result delivery by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module ihq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihq_pkg::dp_stat_t stat,
  output ihq_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DEC, S_CHK, S_PRES, S_POPID, S_RM, S_LAST, S_LPR,
    S_UP, S_UPP, S_UPC, S_DN, S_DN1, S_DN2, S_DNC, S_FIN, S_TOP, S_TOPW
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Next state and command.
  always_comb begin
    state_nxt = state_r;
    cmd       = ihq_pkg::CMD_NOP;
    unique case (state_r)
      S_SWEEP: begin
        cmd = ihq_pkg::CMD_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd       = ihq_pkg::CMD_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.op)
          ihq_pkg::OP_SET, ihq_pkg::OP_REMOVE: begin
            if (stat.range_err) begin
              cmd       = ihq_pkg::CMD_ERR_RANGE;
              state_nxt = S_TOP;
            end else begin
              cmd       = (stat.op == ihq_pkg::OP_SET) ? ihq_pkg::CMD_SET_WR
                                                       : ihq_pkg::CMD_RD_POS;
              state_nxt = S_CHK;
            end
          end
          ihq_pkg::OP_POP: begin
            if (stat.heap_empty) begin
              cmd       = ihq_pkg::CMD_ERR_EMPTY;
              state_nxt = S_TOP;
            end else begin
              cmd       = ihq_pkg::CMD_POP_RD;
              state_nxt = S_POPID;
            end
          end
          ihq_pkg::OP_CLEAR: begin
            cmd       = ihq_pkg::CMD_CLEAR;
            state_nxt = S_TOP;
          end
          default: state_nxt = S_TOP;
        endcase
      end
      S_CHK: begin
        cmd       = ihq_pkg::CMD_CHK;
        state_nxt = S_PRES;
      end
      S_PRES: begin
        if (stat.op == ihq_pkg::OP_SET) begin
          cmd       = stat.present ? ihq_pkg::CMD_PRES : ihq_pkg::CMD_INS;
          state_nxt = S_UP;
        end else if (stat.present) begin
          cmd       = ihq_pkg::CMD_RM_START;
          state_nxt = S_LAST;
        end else begin
          cmd       = ihq_pkg::CMD_ERR_ABSENT;
          state_nxt = S_TOP;
        end
      end
      S_POPID: begin
        cmd       = ihq_pkg::CMD_POP_ID;
        state_nxt = S_RM;
      end
      S_RM: begin
        cmd       = ihq_pkg::CMD_RM_START;
        state_nxt = S_LAST;
      end
      // The last entry moves into the vacated slot unless it was that slot.
      S_LAST: begin
        if (stat.last_eq) begin
          state_nxt = S_TOP;
        end else begin
          cmd       = ihq_pkg::CMD_LD_LAST;
          state_nxt = S_LPR;
        end
      end
      S_LPR: begin
        cmd       = ihq_pkg::CMD_LD_LPR;
        state_nxt = S_UP;
      end
      // Sift up: read parent, its priority, then compare and swap.
      S_UP: begin
        if (stat.up_ok) begin
          cmd       = ihq_pkg::CMD_UP_RD;
          state_nxt = S_UPP;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_UPP: begin
        cmd       = ihq_pkg::CMD_UP_PR;
        state_nxt = S_UPC;
      end
      S_UPC: begin
        cmd       = ihq_pkg::CMD_UP_CMP;
        state_nxt = stat.up_swap ? S_UP : S_DN;
      end
      // Sift down: read both children and their priorities, then compare.
      S_DN: begin
        if (stat.dn_ok) begin
          cmd       = ihq_pkg::CMD_DN_RD;
          state_nxt = S_DN1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN1: begin
        cmd       = ihq_pkg::CMD_DN_C1;
        state_nxt = S_DN2;
      end
      S_DN2: begin
        cmd       = ihq_pkg::CMD_DN_C2;
        state_nxt = S_DNC;
      end
      S_DNC: begin
        cmd       = ihq_pkg::CMD_DN_CMP;
        state_nxt = stat.dn_swap ? S_DN : S_FIN;
      end
      S_FIN: begin
        cmd       = ihq_pkg::CMD_FIN;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        cmd       = ihq_pkg::CMD_TOP_RD;
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        if (!stat.out_busy) begin
          cmd       = ihq_pkg::CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== sv/indexed_max_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Indexed max-heap priority queue unit
// Indexed binary max-heap over NUM_IDS ids with set, remove, pop and clear,
// one result per operation.
//
//   Channel   Direction  Handshake     Payload
//   in_ch     input      valid/ready   operation, item_id, priority_req
//   out_ch    output     valid/ready   status, popped_id, top_valid, top_id,
//                                      entry_count
//
// One operation is in work at a time. Each sift step is paced by the single
// read port on the slot and priority memories.
// After reset the position memory is swept to zero with in_ch.ready low.
// A held result stalls only the delivery of the next one.
// ----------------------------------------------------------------------------
module indexed_max_heap_priority_queue_unit #(
  parameter int NUM_IDS = ihq_pkg::NUM_IDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ihq_in_if.sink   in_ch,
  ihq_out_if.source out_ch
);

  ihq_pkg::cmd_t     cmd;
  ihq_pkg::dp_stat_t stat;

  // Sequencer.
  ihq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memories and sift datapath.
  ihq_datapath #(
    .NUM_IDS (NUM_IDS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_ch.operation),
    .in_item_id      (in_ch.item_id),
    .in_priority_req (in_ch.priority_req),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_popped_id   (out_ch.popped_id),
    .out_top_valid   (out_ch.top_valid),
    .out_top_id      (out_ch.top_id),
    .out_entry_count (out_ch.entry_count)
  );

  // A transfer in closes the request side until the result is issued.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while an operation is in work");

  // Issuing a result always presents it on the result channel.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == ihq_pkg::CMD_RESULT) |=> out_ch.valid)
    else $error("result issued but not presented");

  // A new result is never issued over one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == ihq_pkg::CMD_RESULT) |-> !(out_ch.valid && !out_ch.ready))
    else $error("held result overwritten");

endmodule
